### hw/rtl/dxt1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt1_pkg
// Shared types, constants and helper functions for the DXT1 block decoder.
// ----------------------------------------------------------------------------
package dxt1_pkg;

    localparam int PIXELS     = 16;
    localparam int IDX_W      = 4;
    localparam int SEL_W      = 2;
    localparam int CODES_W    = PIXELS * SEL_W;
    localparam int COLOR_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 10;
    localparam int PAL_SIZE   = 4;

    // Palette entry codes.
    localparam logic [SEL_W-1:0] SEL_END0 = 2'd0;
    localparam logic [SEL_W-1:0] SEL_END1 = 2'd1;
    localparam logic [SEL_W-1:0] SEL_MIX0 = 2'd2;
    localparam logic [SEL_W-1:0] SEL_MIX1 = 2'd3;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    // x / 3 == (x * 683) >> 11 for every x below 2048.
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = 2 * SUM_W;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_rgb;

    // One decoded palette with the indices of its block.
    typedef struct packed {
        t_rgb [PAL_SIZE-1:0]  color;
        logic                 trans3;
        logic [CODES_W-1:0]   codes;
    } t_pal_item;

    function automatic t_rgb widen565(input logic [COLOR_W-1:0] c);
        t_rgb w;
        w.r = {c[15:11], 3'b000};
        w.g = {c[10:5], 2'b00};
        w.b = {c[4:0], 3'b000};
        return w;
    endfunction

    function automatic logic [CHAN_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(DIV3_MUL);
        return prod[DIV3_SHIFT +: CHAN_W];
    endfunction

endpackage

### hw/rtl/dxt1_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt1_palette
// Three-stage pipeline that turns an endpoint pair into a four-entry palette.
// ----------------------------------------------------------------------------
module dxt1_palette (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dxt1_pkg::COLOR_W-1:0]  i_color_zero,
    input  logic [dxt1_pkg::COLOR_W-1:0]  i_color_one,
    input  logic [dxt1_pkg::CODES_W-1:0]  i_pixel_codes,
    output logic                          o_valid,
    input  logic                          i_ready,
    output dxt1_pkg::t_pal_item           o_item
);
    import dxt1_pkg::*;

    typedef struct packed {
        t_rgb               e0;
        t_rgb               e1;
        logic               opaque;
        logic [CODES_W-1:0] codes;
    } t_s1;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_sum;

    typedef struct packed {
        t_rgb               e0;
        t_rgb               e1;
        t_sum               near0;
        t_sum               near1;
        t_rgb               avg;
        logic               opaque;
        logic [CODES_W-1:0] codes;
    } t_s2;

    logic      r_vld1, r_vld2, r_vld3;
    t_s1       r_s1;
    t_s2       r_s2;
    t_pal_item r_s3;
    t_s1       n_s1;
    t_s2       n_s2;
    t_pal_item n_s3;
    logic      en1, en2, en3;

    assign en3     = !r_vld3 || i_ready;
    assign en2     = !r_vld2 || en3;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;
    assign o_valid = r_vld3;
    assign o_item  = r_s3;

    always_comb begin
        n_s1.e0     = widen565(i_color_zero);
        n_s1.e1     = widen565(i_color_one);
        n_s1.opaque = i_color_zero > i_color_one;
        n_s1.codes  = i_pixel_codes;
    end

    // The weighted sums feed the divide by three in the next stage.
    always_comb begin
        logic [CHAN_W:0] sr, sg, sb;
        sr = {1'b0, r_s1.e0.r} + {1'b0, r_s1.e1.r};
        sg = {1'b0, r_s1.e0.g} + {1'b0, r_s1.e1.g};
        sb = {1'b0, r_s1.e0.b} + {1'b0, r_s1.e1.b};
        n_s2.e0      = r_s1.e0;
        n_s2.e1      = r_s1.e1;
        n_s2.near0.r = {2'b00, r_s1.e0.r} + SUM_W'(sr) + SUM_W'(1);
        n_s2.near0.g = {2'b00, r_s1.e0.g} + SUM_W'(sg) + SUM_W'(1);
        n_s2.near0.b = {2'b00, r_s1.e0.b} + SUM_W'(sb) + SUM_W'(1);
        n_s2.near1.r = {2'b00, r_s1.e1.r} + SUM_W'(sr) + SUM_W'(1);
        n_s2.near1.g = {2'b00, r_s1.e1.g} + SUM_W'(sg) + SUM_W'(1);
        n_s2.near1.b = {2'b00, r_s1.e1.b} + SUM_W'(sb) + SUM_W'(1);
        n_s2.avg.r   = sr[CHAN_W:1];
        n_s2.avg.g   = sg[CHAN_W:1];
        n_s2.avg.b   = sb[CHAN_W:1];
        n_s2.opaque  = r_s1.opaque;
        n_s2.codes   = r_s1.codes;
    end

    always_comb begin
        n_s3.color[SEL_END0] = r_s2.e0;
        n_s3.color[SEL_END1] = r_s2.e1;
        if (r_s2.opaque) begin
            n_s3.color[SEL_MIX0].r = div3(r_s2.near0.r);
            n_s3.color[SEL_MIX0].g = div3(r_s2.near0.g);
            n_s3.color[SEL_MIX0].b = div3(r_s2.near0.b);
            n_s3.color[SEL_MIX1].r = div3(r_s2.near1.r);
            n_s3.color[SEL_MIX1].g = div3(r_s2.near1.g);
            n_s3.color[SEL_MIX1].b = div3(r_s2.near1.b);
        end else begin
            n_s3.color[SEL_MIX0] = r_s2.avg;
            n_s3.color[SEL_MIX1] = '0;
        end
        n_s3.trans3 = !r_s2.opaque;
        n_s3.codes  = r_s2.codes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_valid;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
        if (en2) r_s2 <= n_s2;
        if (en3) r_s3 <= n_s3;
    end

`ifndef SYNTHESIS
    a_trans_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 && r_s3.trans3 |-> r_s3.color[SEL_MIX1] == '0)
        else $error("transparent palette entry is not black");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 && !i_ready |=> r_vld3 && $stable(r_s3))
        else $error("stalled palette item changed");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 && !en3 |=> r_vld2 && $stable(r_s2))
        else $error("stalled middle stage item changed");
`endif

endmodule

### hw/rtl/dxt1_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt1_serializer
// Emits the sixteen pixels of a decoded block, one per cycle while the output
// register is not stalled, into that output register.
// ----------------------------------------------------------------------------
module dxt1_serializer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  dxt1_pkg::t_pal_item          i_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dxt1_pkg::IDX_W-1:0]   o_pixel_index,
    output logic [dxt1_pkg::CHAN_W-1:0]  o_red,
    output logic [dxt1_pkg::CHAN_W-1:0]  o_green,
    output logic [dxt1_pkg::CHAN_W-1:0]  o_blue,
    output logic [dxt1_pkg::CHAN_W-1:0]  o_alpha,
    output logic                         o_last
);
    import dxt1_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXELS - 1);

    logic               r_busy;
    logic [IDX_W-1:0]   r_cnt;
    t_rgb [PAL_SIZE-1:0] r_pal;
    logic               r_trans3;
    logic [CODES_W-1:0] r_codes;
    logic               r_o_vld;
    logic [IDX_W-1:0]   r_o_idx;
    t_rgb               r_o_rgb;
    logic [CHAN_W-1:0]  r_o_alpha;
    logic               r_o_last;

    logic               out_free;
    logic               emit;
    logic               take;
    logic [SEL_W-1:0]   sel;

    assign out_free = !r_o_vld || i_out_ready;
    assign emit     = r_busy && out_free;
    // A new block may load on the same edge as the last pixel of the current one.
    assign o_ready  = !r_busy || (emit && r_cnt == LAST_IDX);
    assign take     = i_valid && o_ready;
    assign sel      = r_codes[SEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (emit) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (emit) begin
                r_cnt <= r_cnt + IDX_W'(1);
                if (r_cnt == LAST_IDX) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pal    <= i_item.color;
            r_trans3 <= i_item.trans3;
            r_codes  <= i_item.codes;
        end else if (emit) begin
            r_codes <= {{SEL_W{1'b0}}, r_codes[CODES_W-1:SEL_W]};
        end
        if (emit) begin
            r_o_idx   <= r_cnt;
            r_o_rgb   <= r_pal[sel];
            r_o_alpha <= (sel == SEL_MIX1 && r_trans3) ? ALPHA_CLEAR : ALPHA_OPAQUE;
            r_o_last  <= r_cnt == LAST_IDX;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_pixel_index = r_o_idx;
    assign o_red         = r_o_rgb.r;
    assign o_green       = r_o_rgb.g;
    assign o_blue        = r_o_rgb.b;
    assign o_alpha       = r_o_alpha;
    assign o_last        = r_o_last;

`ifndef SYNTHESIS
    a_clear_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_alpha == ALPHA_CLEAR |-> r_o_rgb == '0)
        else $error("transparent pixel carries color");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && i_out_ready && !r_o_last |=> r_o_vld)
        else $error("gap inside a block");

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_busy && r_cnt == '0)
        else $error("block load did not restart the pixel count");
`endif

endmodule

### hw/rtl/dxt1_block_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt1_block_decoder
// Decodes one DXT1 color block into sixteen RGBA pixels in row-major order.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+------------------------------------
//   input   | i_in_valid  | o_in_ready  | color_zero, color_one, pixel_codes
//   output  | o_out_valid | i_out_ready | pixel_index, rgba, last
//
// A block leaves one pixel per cycle through the output register unless
// i_out_ready stalls it; the next block loads on the edge that emits the last
// pixel. A block passes the three palette stages and the serializer on its way
// to the output register; all of them stall in place and nothing is dropped.
// Reset is synchronous and active low and clears all valid state.
// ----------------------------------------------------------------------------
module dxt1_block_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dxt1_pkg::COLOR_W-1:0] i_color_zero,
    input  logic [dxt1_pkg::COLOR_W-1:0] i_color_one,
    input  logic [dxt1_pkg::CODES_W-1:0] i_pixel_codes,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dxt1_pkg::IDX_W-1:0]   o_pixel_index,
    output logic [dxt1_pkg::CHAN_W-1:0]  o_red,
    output logic [dxt1_pkg::CHAN_W-1:0]  o_green,
    output logic [dxt1_pkg::CHAN_W-1:0]  o_blue,
    output logic [dxt1_pkg::CHAN_W-1:0]  o_alpha,
    output logic                         o_last
);
    import dxt1_pkg::*;

    logic      pal_valid;
    logic      pal_ready;
    t_pal_item pal_item;

    dxt1_palette u_palette (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_color_zero  (i_color_zero),
        .i_color_one   (i_color_one),
        .i_pixel_codes (i_pixel_codes),
        .o_valid       (pal_valid),
        .i_ready       (pal_ready),
        .o_item        (pal_item)
    );

    dxt1_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (pal_valid),
        .o_ready       (pal_ready),
        .i_item        (pal_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_last        (o_last)
    );

endmodule
